// File: rtl/piaw_pkg.sv
// ============================================================================
// piaw_pkg
// Shared types, widths, register indexes and reset values for the PI
// controller with back-calculation anti-windup.
// ============================================================================
`default_nettype none

package piaw_pkg;

    // Default widths of data values and of the error accumulator.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int SUM_WIDTH_DEF  = 48;

    // Gains are signed Q8.24 and always 32 bits wide.
    localparam int GAIN_W     = 32;
    localparam int FRAC_SHIFT = 24;

    // Limit registers keep at least this many bits so that their reset values fit.
    localparam int LIM_MIN_W = 20;

    // Shared multiplier: signed operand, magnitude halves, product and result.
    localparam int OPND_W = 64;
    localparam int HALF_W = OPND_W / 2;
    localparam int PROD_W = OPND_W + GAIN_W;
    localparam int RQ_W   = PROD_W - FRAC_SHIFT;
    localparam int MAG_W  = 62;
    localparam int MRES_W = MAG_W + 1;

    // Products saturate at a magnitude of 2^61.
    localparam logic [MAG_W-1:0] PROD_LIM   = MAG_W'(1) << (MAG_W - 1);
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_SHIFT - 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKCALC_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 3'd4;

    // Register reset values.
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST     = 32'sd16777216;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST    = 32'sd83886;
    localparam logic signed [GAIN_W-1:0] BACKCALC_GAIN_RST = 32'sd83886;
    localparam int UPPER_LIMIT_RST = 327680;
    localparam int LOWER_LIMIT_RST = -327680;

    // Controller sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_START,
        ST_P_WAIT,
        ST_I_START,
        ST_I_WAIT,
        ST_CLAMP,
        ST_DIFF,
        ST_B_START,
        ST_B_WAIT,
        ST_DONE
    } ctrl_state_t;

    // Multiplier sequencer states.
    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI,
        MUL_RND,
        MUL_SGN
    } mul_state_t;

    // Status of the shared multiplier as seen by the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

`default_nettype wire

// File: rtl/piaw_mul.sv
// ============================================================================
// piaw_mul
// Shared Q8.24 gain multiplier: signed operand times signed gain, shifted
// right by 24 with rounding half away from zero, saturated to +-2^61.
// Works on magnitudes, one 32x32 partial product per cycle.
// ============================================================================
`default_nettype none

module piaw_mul
    import piaw_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start_i,
    input  wire logic signed [OPND_W-1:0] a_i,
    input  wire logic signed [GAIN_W-1:0] g_i,
    output mul_status_t                   status_o,
    output logic signed [MRES_W-1:0]      result_o
);

    mul_state_t state_reg, state_next;
    logic       done_reg;

    logic [OPND_W-1:0]       a_mag_reg;
    logic [GAIN_W-1:0]       g_mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic signed [MRES_W-1:0] result_reg;

    logic [OPND_W-1:0] a_mag;
    logic [GAIN_W-1:0] g_mag;
    logic [HALF_W-1:0] a_half;
    logic [OPND_W-1:0] part_prod;
    logic [PROD_W-1:0] rnd_sum;
    logic [RQ_W-1:0]   rnd_q;

    // Operand magnitudes and the partial product of the half in work.
    always_comb begin
        a_mag     = a_i[OPND_W-1] ? (~$unsigned(a_i) + OPND_W'(1)) : $unsigned(a_i);
        g_mag     = g_i[GAIN_W-1] ? (~$unsigned(g_i) + GAIN_W'(1)) : $unsigned(g_i);
        a_half    = (state_reg == MUL_HI) ? a_mag_reg[OPND_W-1:HALF_W]
                                          : a_mag_reg[HALF_W-1:0];
        part_prod = a_half * g_mag_reg;
        rnd_sum   = acc_reg + ROUND_BIAS;
        rnd_q     = rnd_sum[PROD_W-1:FRAC_SHIFT];
    end

    // Sequencer state and the completion flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MUL_SGN);
        end
    end

    // Next state: low half, high half, round and saturate, apply sign.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MUL_IDLE: begin
                if (start_i) begin
                    state_next = MUL_LO;
                end
            end
            MUL_LO:  state_next = MUL_HI;
            MUL_HI:  state_next = MUL_RND;
            MUL_RND: state_next = MUL_SGN;
            MUL_SGN: state_next = MUL_IDLE;
            default: state_next = MUL_IDLE;
        endcase
    end

    // Datapath registers, one step per state.
    always_ff @(posedge aclk) begin
        case (state_reg)
            MUL_IDLE: begin
                if (start_i) begin
                    a_mag_reg <= a_mag;
                    g_mag_reg <= g_mag;
                    neg_reg   <= a_i[OPND_W-1] ^ g_i[GAIN_W-1];
                end
            end
            MUL_LO: begin
                acc_reg <= PROD_W'(part_prod);
            end
            MUL_HI: begin
                acc_reg <= acc_reg + {part_prod, {HALF_W{1'b0}}};
            end
            MUL_RND: begin
                mag_reg <= (rnd_q > RQ_W'(PROD_LIM)) ? PROD_LIM : rnd_q[MAG_W-1:0];
            end
            MUL_SGN: begin
                result_reg <= neg_reg ? (MRES_W'(0) - {1'b0, mag_reg}) : {1'b0, mag_reg};
            end
            default: begin
            end
        endcase
    end

    assign status_o.busy = (state_reg != MUL_IDLE);
    assign status_o.done = done_reg;
    assign result_o      = result_reg;

endmodule

`default_nettype wire

// File: rtl/pi_controller_antiwindup.sv
// ============================================================================
// pi_controller_antiwindup
// Each accepted input transaction passes three times through the shared
// multiplier (operand load, two 32x32 partial products, round, sign).
// One transaction is in work at a time; a new input is taken only after
// the previous result has moved into the output register.
// Reset: synchronous, active low; restores register defaults, clears the
// error sum and empties the output register.
// ============================================================================
`default_nettype none

module pi_controller_antiwindup
    import piaw_pkg::*;
#(
    parameter  int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter  int SUM_WIDTH  = SUM_WIDTH_DEF,
    localparam int CFG_W      = (DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W
)
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration write port.
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_wdata,
    // Input channel.
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_reference,
    input  wire logic signed [DATA_WIDTH-1:0] s_measured,
    // Result channel.
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_drive,
    output logic                              m_clamped
);

    localparam int LIM_W  = (DATA_WIDTH > LIM_MIN_W) ? DATA_WIDTH : LIM_MIN_W;
    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int SUMX_W = ((SUM_WIDTH > OPND_W) ? SUM_WIDTH : OPND_W) + 1;
    localparam logic signed [SUMX_W-1:0] SUM_MAX =
        (SUMX_W'(1) <<< (SUM_WIDTH - 1)) - SUMX_W'(1);
    localparam logic signed [SUMX_W-1:0] SUM_MIN = -SUM_MAX - SUMX_W'(1);

    // Configuration registers.
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] integ_gain_reg;
    logic signed [GAIN_W-1:0] backcalc_gain_reg;
    logic signed [LIM_W-1:0]  upper_limit_reg;
    logic signed [LIM_W-1:0]  lower_limit_reg;

    // Sequencer and controller state.
    ctrl_state_t state_reg, state_next;
    logic signed [SUM_WIDTH-1:0] sum_reg;

    // Working registers.
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [MRES_W-1:0] prod_p_reg;
    logic signed [OPND_W-1:0] u_reg;
    logic signed [LIM_W-1:0]  drive_reg;
    logic                     flag_reg;
    logic signed [OPND_W-1:0] diff_reg;
    logic signed [OPND_W-1:0] d_reg;

    // Output register.
    logic                           m_valid_reg;
    logic signed [DATA_WIDTH-1:0]   m_drive_reg;
    logic                           m_clamped_reg;

    // Multiplier interface.
    logic                     mul_start;
    logic signed [OPND_W-1:0] mul_a;
    logic signed [GAIN_W-1:0] mul_g;
    mul_status_t              mul_status;
    logic signed [MRES_W-1:0] mul_result;

    logic                     out_load;
    logic signed [OPND_W-1:0] upper_ext;
    logic signed [OPND_W-1:0] lower_ext;
    logic signed [SUMX_W-1:0] sum_total;
    logic signed [SUMX_W-1:0] sum_sat;

    piaw_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (mul_start),
        .a_i      (mul_a),
        .g_i      (mul_g),
        .status_o (mul_status),
        .result_o (mul_result)
    );

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= INTEG_GAIN_RST;
            backcalc_gain_reg <= BACKCALC_GAIN_RST;
            upper_limit_reg   <= LIM_W'(UPPER_LIMIT_RST);
            lower_limit_reg   <= LIM_W'(LOWER_LIMIT_RST);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:    integ_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_BACKCALC_GAIN: backcalc_gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_UPPER_LIMIT:
                    upper_limit_reg <= LIM_W'(signed'(cfg_wdata[DATA_WIDTH-1:0]));
                REG_LOWER_LIMIT:
                    lower_limit_reg <= LIM_W'(signed'(cfg_wdata[DATA_WIDTH-1:0]));
                default: begin
                end
            endcase
        end
    end

    // Limits, accumulator update and saturation at the sum width.
    always_comb begin
        upper_ext = OPND_W'(upper_limit_reg);
        lower_ext = OPND_W'(lower_limit_reg);
        sum_total = SUMX_W'(sum_reg) + SUMX_W'(d_reg);
        if (sum_total > SUM_MAX) begin
            sum_sat = SUM_MAX;
        end else if (sum_total < SUM_MIN) begin
            sum_sat = SUM_MIN;
        end else begin
            sum_sat = sum_total;
        end
    end

    // Multiplier operand selection per pass.
    always_comb begin
        case (state_reg)
            ST_P_START: begin
                mul_a = OPND_W'(err_reg);
                mul_g = prop_gain_reg;
            end
            ST_I_START: begin
                mul_a = OPND_W'(sum_reg);
                mul_g = integ_gain_reg;
            end
            default: begin
                mul_a = diff_reg;
                mul_g = backcalc_gain_reg;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and control outputs.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mul_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_P_START;
                end
            end
            ST_P_START: begin
                if (!mul_status.busy) begin
                    mul_start  = 1'b1;
                    state_next = ST_P_WAIT;
                end
            end
            ST_P_WAIT: begin
                if (mul_status.done) begin
                    state_next = ST_I_START;
                end
            end
            ST_I_START: begin
                if (!mul_status.busy) begin
                    mul_start  = 1'b1;
                    state_next = ST_I_WAIT;
                end
            end
            ST_I_WAIT: begin
                if (mul_status.done) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_B_START;
            ST_B_START: begin
                if (!mul_status.busy) begin
                    mul_start  = 1'b1;
                    state_next = ST_B_WAIT;
                end
            end
            ST_B_WAIT: begin
                if (mul_status.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand over once the output register is free or being emptied.
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Working registers, loaded step by step.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_reg <= ERR_W'(s_reference) - ERR_W'(s_measured);
                end
            end
            ST_P_WAIT: begin
                if (mul_status.done) begin
                    prod_p_reg <= mul_result;
                end
            end
            ST_I_WAIT: begin
                if (mul_status.done) begin
                    u_reg <= OPND_W'(prod_p_reg) + OPND_W'(mul_result);
                end
            end
            ST_CLAMP: begin
                // The upper limit is tested first; with crossed limits, u above it gives the upper one, else the lower.
                if (u_reg > upper_ext) begin
                    drive_reg <= upper_limit_reg;
                    flag_reg  <= 1'b1;
                end else if (u_reg < lower_ext) begin
                    drive_reg <= lower_limit_reg;
                    flag_reg  <= 1'b1;
                end else begin
                    drive_reg <= LIM_W'(u_reg);
                    flag_reg  <= 1'b0;
                end
            end
            ST_DIFF: begin
                diff_reg <= OPND_W'(drive_reg) - u_reg;
            end
            ST_B_WAIT: begin
                if (mul_status.done) begin
                    d_reg <= OPND_W'(err_reg) + OPND_W'(mul_result);
                end
            end
            default: begin
            end
        endcase
    end

    // Error sum: cleared by reset, updated when the result is handed over.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (out_load) begin
            sum_reg <= SUM_WIDTH'(sum_sat);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_drive_reg   <= drive_reg[DATA_WIDTH-1:0];
            m_clamped_reg <= flag_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_drive   = m_drive_reg;
    assign m_clamped = m_clamped_reg;

endmodule

`default_nettype wire

// File: rtl/piaw_checker.sv
// ============================================================================
// piaw_checker
// Port-level checks for the PI controller: busy period after an accepted
// transaction, result ordering against input acceptance, result holding while stalled, and reset.
// ============================================================================
`default_nettype none

module piaw_checker
    import piaw_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic signed [DATA_WIDTH-1:0] m_drive,
    input wire logic                         m_clamped
);

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous transaction still in work");

    // No result appears right after an input is taken into an empty output.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared before the computation could finish");

    // A new result is produced only while the input side is closed.
    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result produced while the block was idle");

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_drive) && $stable(m_clamped)))
        else $error("result changed or dropped while stalled");

endmodule

bind pi_controller_antiwindup piaw_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_piaw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_drive   (m_drive),
    .m_clamped (m_clamped)
);

`default_nettype wire

// File: bench/tb_pi_controller_antiwindup.sv
// ============================================================================
// tb_pi_controller_antiwindup
// Self-checking bench for the PI controller with back-calculation
// anti-windup. A bit-accurate predictor, fed at each accepted input
// transaction, keeps the expected drive values and clamp flags in order.
// Each result transaction is checked against them. Directed tests cover
// the extreme fields, crossed limits, product and accumulator saturation,
// and writes to unused register indexes. Random traffic then runs under
// changing register settings, handshake idling and one long output stall.
// ============================================================================
`default_nettype none

module tb_pi_controller_antiwindup;
    timeunit 1ns;
    timeprecision 1ps;

    import piaw_pkg::*;

    localparam int DW = 32;
    localparam int SW = 48;
    localparam int WIDE = 128;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 40;
    localparam int BATCH_ITEMS = 30;
    localparam int PRESSURE_CYCLES = 300;

    typedef logic signed [WIDE-1:0] wide_t;

    localparam wide_t PRODUCT_LIMIT = wide_t'(1) <<< 61;
    localparam wide_t ERR_SUM_MAX = (wide_t'(1) <<< (SW - 1)) - 1;
    localparam wide_t ERR_SUM_MIN = -(wide_t'(1) <<< (SW - 1));

    localparam logic [DW-1:0] DATA_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] DATA_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic                 clamped;
    } drive_result_t;

    // Clock, reset and block ports.
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DW-1:0]         cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [DW-1:0]  s_reference = '0;
    logic signed [DW-1:0]  s_measured = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [DW-1:0]  m_drive;
    logic                  m_clamped;

    // Predictor copy of the registers and the error accumulator.
    logic signed [31:0]    pred_prop_gain;
    logic signed [31:0]    pred_integ_gain;
    logic signed [31:0]    pred_backcalc_gain;
    logic signed [DW-1:0]  pred_upper_limit;
    logic signed [DW-1:0]  pred_lower_limit;
    logic signed [SW-1:0]  pred_error_sum;

    drive_result_t         expected_drive_q[$];
    int                    mismatch_count = 0;
    int                    sample_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;

    // Long output stall request, toggled by the stimulus and acknowledged below.
    logic                  stall_req = 1'b0;
    logic                  stall_ack = 1'b0;
    int                    stall_left = 0;

    always #5 aclk = ~aclk;

    pi_controller_antiwindup u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_reference (s_reference),
        .s_measured  (s_measured),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive     (m_drive),
        .m_clamped   (m_clamped)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Gain product in Q8.24: magnitude rounded half away from zero, then saturated.
    function automatic wide_t scale_q24(input wide_t value, input logic signed [31:0] gain);
        wide_t mag_v;
        wide_t mag_g;
        wide_t mag;
        logic  neg;
        neg   = (value < 0) != (gain < 0);
        mag_v = (value < 0) ? -value : value;
        mag_g = (gain < 0) ? -wide_t'(gain) : wide_t'(gain);
        mag   = (mag_v * mag_g + (wide_t'(1) <<< 23)) >>> 24;
        if (mag > PRODUCT_LIMIT) begin
            mag = PRODUCT_LIMIT;
        end
        return neg ? -mag : mag;
    endfunction

    task automatic reset_predictor();
        pred_prop_gain     = PROP_GAIN_RST;
        pred_integ_gain    = INTEG_GAIN_RST;
        pred_backcalc_gain = BACKCALC_GAIN_RST;
        pred_upper_limit   = UPPER_LIMIT_RST;
        pred_lower_limit   = LOWER_LIMIT_RST;
        pred_error_sum     = '0;
    endtask

    task automatic store_register(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
        case (idx)
            REG_PROP_GAIN:     pred_prop_gain = val;
            REG_INTEG_GAIN:    pred_integ_gain = val;
            REG_BACKCALC_GAIN: pred_backcalc_gain = val;
            REG_UPPER_LIMIT:   pred_upper_limit = val;
            REG_LOWER_LIMIT:   pred_lower_limit = val;
            default: ;
        endcase
    endtask

    // One control step: clamped drive, flag, then the anti-windup sum update.
    task automatic predict_drive(input logic signed [DW-1:0] ref_val,
                                 input logic signed [DW-1:0] meas_val);
        wide_t         err;
        wide_t         u;
        wide_t         drv;
        wide_t         upper;
        wide_t         lower;
        wide_t         sum;
        drive_result_t res;
        err   = wide_t'(ref_val) - wide_t'(meas_val);
        u     = scale_q24(err, pred_prop_gain)
                + scale_q24(wide_t'(pred_error_sum), pred_integ_gain);
        upper = wide_t'(pred_upper_limit);
        lower = wide_t'(pred_lower_limit);
        res.clamped = 1'b1;
        if (u > upper) begin
            drv = upper;
        end else if (u < lower) begin
            drv = lower;
        end else begin
            drv = u;
            res.clamped = 1'b0;
        end
        res.drive = drv[DW-1:0];
        sum = wide_t'(pred_error_sum) + err + scale_q24(drv - u, pred_backcalc_gain);
        if (sum > ERR_SUM_MAX) begin
            sum = ERR_SUM_MAX;
        end else if (sum < ERR_SUM_MIN) begin
            sum = ERR_SUM_MIN;
        end
        pred_error_sum = sum[SW-1:0];
        expected_drive_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Result checking and output-side flow control
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_result();
        drive_result_t exp_res;
        if (expected_drive_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result drive=%0d clamped=%0b",
                                      m_drive, m_clamped));
        end else begin
            exp_res = expected_drive_q.pop_front();
            if (m_drive !== exp_res.drive) begin
                report_mismatch($sformatf("drive %0d, expected %0d", m_drive, exp_res.drive));
            end
            if (m_clamped !== exp_res.clamped) begin
                report_mismatch($sformatf("clamped %0b, expected %0b",
                                          m_clamped, exp_res.clamped));
            end
        end
    endtask

    // Checks each result transaction, then decides ready for the next edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (stall_req != stall_ack) begin
                stall_ack  <= stall_req;
                stall_left <= PRESSURE_CYCLES;
                m_ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one input transaction and predicts its result once accepted.
    task automatic send_sample(input logic [DW-1:0] ref_val, input logic [DW-1:0] meas_val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_reference <= ref_val;
        s_measured  <= meas_val;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_drive(ref_val, meas_val);
        sample_count++;
    endtask

    // Waits until every expected result has been taken and the block is quiet.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_drive_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        store_register(idx, val);
    endtask

    task automatic configure(input logic [31:0] prop, input logic [31:0] integ,
                             input logic [31:0] backcalc, input logic [DW-1:0] upper,
                             input logic [DW-1:0] lower);
        write_register(REG_PROP_GAIN, prop);
        write_register(REG_INTEG_GAIN, integ);
        write_register(REG_BACKCALC_GAIN, backcalc);
        write_register(REG_UPPER_LIMIT, upper);
        write_register(REG_LOWER_LIMIT, lower);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Mostly gains between -1.0 and +1.0, sometimes the extremes, zero or any value.
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_limit();
        case ($urandom_range(7))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return $urandom;
            default: return $urandom_range(0, 40 << 16) - (20 << 16);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32 << 16) - (16 << 16);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic apply_reset();
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // Reset register values with the extremes of both input fields.
    task automatic test_default_settings();
        send_sample('0, '0);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(DATA_MIN, DATA_MAX);
        send_sample(DATA_MAX, DATA_MAX);
        send_sample(DATA_MIN, DATA_MIN);
        send_sample(32'h0001_8000, 32'h0000_4000);
        send_sample(32'hFFFF_0000, 32'h0000_0001);
        drain_block();
    endtask

    // Lower limit above upper limit: drive always lands on one of them.
    task automatic test_crossed_limits();
        configure(32'h0100_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        send_sample('0, '0);
        send_sample(32'h0000_8000, '0);
        send_sample(32'h0010_0000, '0);
        send_sample('0, 32'h0010_0000);
        drain_block();
    endtask

    // Extreme gains and narrow limits drive the products and the sum into saturation.
    task automatic test_saturation();
        configure(DATA_MAX, DATA_MAX, DATA_MAX, 32'h0000_0001, 32'hFFFF_FFFF);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(DATA_MIN, DATA_MAX);
        send_sample(DATA_MIN, DATA_MAX);
        drain_block();
        configure(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MIN);
        send_sample(DATA_MAX, DATA_MIN);
        send_sample(DATA_MIN, DATA_MAX);
        drain_block();
    endtask

    // Writes to indexes past the last register must leave everything unchanged.
    task automatic test_ignored_index();
        configure(PROP_GAIN_RST, INTEG_GAIN_RST, BACKCALC_GAIN_RST,
                  UPPER_LIMIT_RST, LOWER_LIMIT_RST);
        for (int k = REG_LOWER_LIMIT + 1; k < (1 << CFG_IDX_W); k++) begin
            write_register(k[CFG_IDX_W-1:0], $urandom);
        end
        cfg_wr_en <= 1'b0;
        send_sample(32'h0003_0000, '0);
        send_sample(32'h0009_0000, '0);
        send_sample('0, 32'h0009_0000);
        drain_block();
    endtask

    // Batches of a slowly moving setpoint with noisy feedback, under fresh settings.
    task automatic test_random_traffic(input int item_count);
        logic [DW-1:0] setpoint;
        logic [DW-1:0] upper;
        logic [DW-1:0] lower;
        logic [DW-1:0] meas;
        int            stop_at;
        stop_at = sample_count + item_count;
        while (sample_count < stop_at) begin
            upper = pick_limit();
            lower = pick_limit();
            // Usually ordered limits; one batch in ten makes them crossed.
            if (($urandom_range(9) != 0) == ($signed(upper) < $signed(lower))) begin
                {upper, lower} = {lower, upper};
            end
            configure(pick_gain(), pick_gain(), pick_gain(), upper, lower);
            setpoint = pick_value();
            for (int n = 0; n < BATCH_ITEMS; n++) begin
                if ($urandom_range(9) < 2) begin
                    send_sample(pick_value(), pick_value());
                end else begin
                    meas = setpoint + $urandom_range(0, 1 << 18) - (1 << 17);
                    send_sample(setpoint, meas);
                    if ($urandom_range(7) == 0) begin
                        setpoint = pick_value();
                    end
                end
            end
            drain_block();
        end
    endtask

    // The result side stops for a long stretch while inputs keep coming.
    task automatic test_output_backpressure();
        configure(PROP_GAIN_RST, INTEG_GAIN_RST, BACKCALC_GAIN_RST,
                  UPPER_LIMIT_RST, LOWER_LIMIT_RST);
        stall_req <= ~stall_req;
        for (int n = 0; n < 24; n++) begin
            send_sample(pick_value(), pick_value());
        end
        drain_block();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        apply_reset();
        set_idling(14, 70);
        test_default_settings();
        test_crossed_limits();
        test_saturation();
        test_ignored_index();
        test_random_traffic(500);
        set_idling(70, 14);
        test_random_traffic(500);
        set_idling(0, 0);
        test_output_backpressure();
        test_random_traffic(480);
        drain_block();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(8_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/piaw_pkg.sv
rtl/piaw_mul.sv
rtl/pi_controller_antiwindup.sv
rtl/piaw_checker.sv
bench/tb_pi_controller_antiwindup.sv
